### src/pcanon_pkg.sv
package pcanon_pkg;

    localparam logic [7:0] NUL_BYTE = 8'd0;
    localparam logic [7:0] DOT_BYTE = 8'd46;
    localparam logic [7:0] SEP_BYTE = 8'd47;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;     // an input byte is accepted this cycle
        logic close;    // fold the open component in at the end of the path
        logic clear;    // the final result is taken; return to the empty state
        logic k_clr;    // restart the read pointer of the output buffer
        logic k_inc;    // step the read pointer
        logic err_res;  // present the error result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic close_item;  // the accepted byte closes a component
        logic fail;        // error raised or canonical path empty
        logic k_last;      // the read pointer is on the final byte
    } t_sts;

endpackage

### src/pcanon_ram.sv
module pcanon_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/pcanon_ctrl.sv
module pcanon_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  pcanon_pkg::t_sts i_sts,
    output pcanon_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SETTLE   = 7'b0000010,
        ST_CLOSE    = 7'b0000100,
        ST_PICK     = 7'b0001000,
        ST_EMIT_RD  = 7'b0010000,
        ST_EMIT_OUT = 7'b0100000,
        ST_ERR_OUT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.take = i_valid;
                if (i_valid) begin
                    if (i_last) begin
                        n_state = ST_CLOSE;
                    end else if (i_sts.close_item) begin
                        // The stack read port is registered; ST_SETTLE lets it show the new top.
                        n_state = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE: begin
                n_state = ST_IDLE;
            end
            ST_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state     = ST_PICK;
            end
            ST_PICK: begin
                o_cmd.k_clr = 1'b1;
                n_state     = i_sts.fail ? ST_ERR_OUT : ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (!i_stall) begin
                    if (i_sts.k_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = ST_EMIT_RD;
                    end
                end
            end
            ST_ERR_OUT: begin
                o_cmd.err_res = 1'b1;
                if (!i_stall) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_EMIT_OUT) || (r_state == ST_ERR_OUT);

endmodule

### src/pcanon_dp.sv
module pcanon_dp #(
    parameter int PATH_CAPACITY = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pcanon_pkg::t_cmd i_cmd,
    input  logic [7:0]       i_ch,
    output pcanon_pkg::t_sts o_sts,
    output logic [7:0]       o_ch_res,
    output logic             o_error,
    output logic             o_last_res
);

    localparam int AW = $clog2(PATH_CAPACITY);
    localparam int SD = PATH_CAPACITY / 2;
    localparam int SW = $clog2(SD);
    localparam int PW = $clog2(SD + 1);
    localparam logic [AW:0] CAP_W = (AW + 1)'(PATH_CAPACITY);

    logic [AW-1:0] r_out_len,  n_out_len;
    logic [AW-1:0] r_comp_len, n_comp_len;
    logic          r_d0,       n_d0;
    logic          r_d1,       n_d1;
    logic          r_err,      n_err;
    logic          r_ended,    n_ended;
    logic [PW-1:0] r_sp,       n_sp;
    logic [AW-1:0] r_k,        n_k;

    logic          active;
    logic          is_zero;
    logic          is_sep;
    logic          item_byte;
    logic          item_close;
    logic          do_close;
    logic          has_out;
    logic [AW:0]   base;
    logic [AW:0]   end_pos;
    logic          comp_full;
    logic          fits;
    logic          is_dot;
    logic          is_dd;
    logic          nonempty;
    logic          commit;
    logic          pop;
    logic          sep_err;
    logic          commit_ok;
    logic [AW-1:0] top;
    logic [AW-1:0] out_rdata;
    logic          out_we;
    logic [AW-1:0] out_waddr;
    logic [7:0]    out_wdata;
    logic [7:0]    o_ch_res_raw;

    assign active     = !r_err && !r_ended;
    assign is_zero    = (i_ch == pcanon_pkg::NUL_BYTE);
    assign is_sep     = (i_ch == pcanon_pkg::SEP_BYTE);
    assign item_byte  = i_cmd.take && active && !is_zero && !is_sep;
    assign item_close = i_cmd.take && active && (is_zero || is_sep);
    assign do_close   = item_close || (i_cmd.close && active);

    // Component bytes go straight to their final place in the output buffer,
    // one past the separator that a commit would add.
    assign has_out   = (r_out_len != '0);
    assign base      = {1'b0, r_out_len} + (AW + 1)'(has_out);
    assign end_pos   = base + {1'b0, r_comp_len};
    assign comp_full = ({1'b0, r_comp_len} + (AW + 1)'(1)) >= CAP_W;
    assign fits      = end_pos < CAP_W;

    assign nonempty  = (r_comp_len != '0);
    assign is_dot    = (r_comp_len == AW'(1)) && r_d0;
    assign is_dd     = (r_comp_len == AW'(2)) && r_d0 && r_d1;
    assign commit    = do_close && nonempty && !is_dot && !is_dd;
    assign pop       = do_close && is_dd && has_out;
    assign sep_err   = has_out && (({1'b0, r_out_len} + (AW + 1)'(1)) >= CAP_W);
    assign commit_ok = commit && !sep_err && fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_len  <= '0;
            r_comp_len <= '0;
            r_d0       <= 1'b0;
            r_d1       <= 1'b0;
            r_err      <= 1'b0;
            r_ended    <= 1'b0;
            r_sp       <= '0;
            r_k        <= '0;
        end else begin
            r_out_len  <= n_out_len;
            r_comp_len <= n_comp_len;
            r_d0       <= n_d0;
            r_d1       <= n_d1;
            r_err      <= n_err;
            r_ended    <= n_ended;
            r_sp       <= n_sp;
            r_k        <= n_k;
        end
    end

    always_comb begin
        n_out_len  = r_out_len;
        n_comp_len = r_comp_len;
        n_d0       = r_d0;
        n_d1       = r_d1;
        n_err      = r_err;
        n_ended    = r_ended;
        n_sp       = r_sp;
        n_k        = r_k;
        if (i_cmd.clear) begin
            n_out_len  = '0;
            n_comp_len = '0;
            n_d0       = 1'b0;
            n_d1       = 1'b0;
            n_err      = 1'b0;
            n_ended    = 1'b0;
            n_sp       = '0;
            n_k        = '0;
        end else begin
            if (item_byte) begin
                if (comp_full) begin
                    n_err = 1'b1;
                end else begin
                    n_comp_len = r_comp_len + AW'(1);
                    if (r_comp_len == '0) begin
                        n_d0 = (i_ch == pcanon_pkg::DOT_BYTE);
                    end
                    if (r_comp_len == AW'(1)) begin
                        n_d1 = (i_ch == pcanon_pkg::DOT_BYTE);
                    end
                end
            end
            if (do_close) begin
                n_comp_len = '0;
                n_d0       = 1'b0;
                n_d1       = 1'b0;
                if (commit) begin
                    if (commit_ok) begin
                        n_out_len = end_pos[AW-1:0];
                        n_sp      = r_sp + PW'(1);
                    end else begin
                        n_err = 1'b1;
                    end
                end
                if (pop) begin
                    // Drop the last component together with the slash before it.
                    n_out_len = (top == '0) ? '0 : top - AW'(1);
                    n_sp      = r_sp - PW'(1);
                end
            end
            if (item_close && is_zero) begin
                n_ended = 1'b1;
            end
            if (i_cmd.k_clr) begin
                n_k = '0;
            end else if (i_cmd.k_inc) begin
                n_k = r_k + AW'(1);
            end
        end
    end

    assign out_we    = (item_byte && !comp_full && fits) || (commit && has_out);
    assign out_waddr = item_byte ? end_pos[AW-1:0] : r_out_len;
    assign out_wdata = item_byte ? i_ch : pcanon_pkg::SEP_BYTE;

    pcanon_ram #(
        .WIDTH (8),
        .DEPTH (PATH_CAPACITY)
    ) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (out_waddr),
        .i_wdata (out_wdata),
        .i_raddr (r_k),
        .o_rdata (o_ch_res_raw)
    );

    // Start positions of the committed components; the read port always
    // looks at the top entry.
    pcanon_ram #(
        .WIDTH (AW),
        .DEPTH (SD)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (commit_ok),
        .i_waddr (r_sp[SW-1:0]),
        .i_wdata (base[AW-1:0]),
        .i_raddr (SW'(r_sp - PW'(1))),
        .o_rdata (top)
    );

    assign out_rdata = r_out_len - AW'(1);

    assign o_sts.close_item = item_close;
    assign o_sts.fail       = r_err || !has_out;
    assign o_sts.k_last     = (r_k == out_rdata);

    assign o_ch_res   = i_cmd.err_res ? 8'd0 : o_ch_res_raw;
    assign o_error    = i_cmd.err_res;
    assign o_last_res = i_cmd.err_res || o_sts.k_last;

endmodule

### src/path_canonicalizer.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_ch[7:0], i_last
// output    out        o_valid / i_stall    o_ch_res[7:0], o_error, o_last_res
//
// A path byte that is not marked last is taken in ST_IDLE; one that closes a component
// also passes ST_SETTLE, while the component-start stack RAM presents its new top.
// The last byte then passes ST_CLOSE and ST_PICK. The error result goes out in ST_ERR_OUT;
// each canonical byte is read from the output buffer RAM in ST_EMIT_RD, sent in ST_EMIT_OUT.
// i_rst_n is synchronous and clears the control and datapath registers but not the RAMs;
// no clearing pass is needed. While results go out the input side is stalled, and i_stall holds the current result.
module path_canonicalizer #(
    parameter int PATH_CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_ch_res,
    output logic       o_error,
    output logic       o_last_res
);

    pcanon_pkg::t_cmd cmd;
    pcanon_pkg::t_sts sts;

    pcanon_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pcanon_dp #(
        .PATH_CAPACITY (PATH_CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_ch       (i_ch),
        .o_sts      (sts),
        .o_ch_res   (o_ch_res),
        .o_error    (o_error),
        .o_last_res (o_last_res)
    );

endmodule
